### rtl/bffa_pkg.sv
// Shared constants, codes and types of the bitmap first-free allocator.
package bffa_pkg;

    // Map geometry
    localparam int MAX_ITEMS = 1024;
    localparam int WORD_W    = 32;
    localparam int BSEL_W    = $clog2(WORD_W);
    localparam int MAP_WORDS = (MAX_ITEMS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int MAP_DEPTH = 1 << WADDR_W;
    localparam int BIT_W     = WADDR_W + BSEL_W;
    // Width wide enough to compare item indexes against the 11-bit limit
    localparam int CMP_W     = (BIT_W + 1 > 12) ? (BIT_W + 1) : 12;
    localparam int AVAIL_W   = BSEL_W + 1;

    // Field widths
    localparam int FIELD_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int OUT_W     = STATUS_W + FIELD_W + FIELD_W;

    // Count bounds and reset values
    localparam int COUNT_LIMIT_I = (MAX_ITEMS < 2047) ? MAX_ITEMS : 2047;
    localparam logic [FIELD_W-1:0] COUNT_LIMIT = FIELD_W'(COUNT_LIMIT_I);
    localparam logic [FIELD_W-1:0] ITEMS_RESET = 11'd1024;
    localparam logic [FIELD_W-1:0] INIT_FREE_RESET = 11'd1024;
    localparam logic [FIELD_W-1:0] FREE_RESET =
        (1024 > COUNT_LIMIT_I) ? COUNT_LIMIT : 11'd1024;

    // Request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Register indexes
    localparam logic REG_ITEM_COUNT   = 1'b0;
    localparam logic REG_INITIAL_FREE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Request into the word unit
    typedef struct packed {
        logic                op;     // MODE_ALLOC or MODE_FREE
        logic [WORD_W-1:0]   word;   // map word as read
        logic [AVAIL_W-1:0]  avail;  // bits of this word below the limit
        logic [BSEL_W-1:0]   pos;    // bit to clear on free
    } word_req_t;

    // Answer from the word unit
    typedef struct packed {
        logic                found;  // clear bit found (allocate)
        logic [BSEL_W-1:0]   pos;    // lowest clear bit
        logic [WORD_W-1:0]   wdata;  // word to write back
    } word_res_t;

endpackage

### rtl/bffa_map.sv
// Allocation bitmap storage: one map word per row, registered read, row valid bits.
module bffa_map
    import bffa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [WADDR_W-1:0]  rd_addr,
    input  logic                wr_en,
    input  logic [WADDR_W-1:0]  wr_addr,
    input  logic [WORD_W-1:0]   wr_data,
    output logic [WORD_W-1:0]   rd_data
);

    logic [WORD_W-1:0]    mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] row_valid_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;

    // Word array, one write and one read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Rows never written since reset read as all free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/bffa_word_unit.sv
// Shared word unit: lowest clear bit below the limit, and bit set/clear for write-back.
module bffa_word_unit
    import bffa_pkg::*;
(
    input  word_req_t req,
    output word_res_t res
);

    logic [WORD_W-1:0] in_range;
    logic [WORD_W-1:0] eff;
    logic [BSEL_W-1:0] hit_pos;
    logic              hit;
    logic [BSEL_W-1:0] mod_pos;

    // Bits at or above the limit count as used
    always_comb begin
        if (req.avail >= AVAIL_W'(WORD_W)) begin
            in_range = '1;
        end else begin
            in_range = (WORD_W'(1) << req.avail[BSEL_W-1:0]) - WORD_W'(1);
        end
        eff = req.word | ~in_range;
    end

    // Priority encoder, lowest clear bit wins
    always_comb begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!eff[i]) begin
                hit     = 1'b1;
                hit_pos = BSEL_W'(i);
            end
        end
    end

    // Modified word for write-back
    assign mod_pos = (req.op == MODE_ALLOC) ? hit_pos : req.pos;

    always_comb begin
        res.found = hit;
        res.pos   = hit_pos;
        if (req.op == MODE_ALLOC) begin
            res.wdata = req.word | (WORD_W'(1) << mod_pos);
        end else begin
            res.wdata = req.word & ~(WORD_W'(1) << mod_pos);
        end
    end

endmodule

### rtl/bitmap_first_free_allocator.sv
// Top level of the bitmap first-free allocator: stream ports, register port, sequencer.
//
// Each request is one transaction in and one result transaction out. An allocate
// scans the map one 32-bit word per cycle from word 0 up, with at least one word
// read, and stops early when a free item is found; a free reads and writes back
// only the word that holds its item, and an out-of-range number reads no word.
// The single read port of the map memory sets this rate.
// One request is worked at a time, but the next may be accepted while a result
// still waits on m_tready.
// The map needs no clearing pass after reset: per-row valid bits make every item
// read as free until its row is first written. Registers: item_count at 0x0,
// initial_free at 0x4 (writing it reloads the free count).
module bitmap_first_free_allocator
    import bffa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [10:0] item_number, [15:11] zero
    input  logic [0:0]          s_tuser,   // [0] mode
    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // [1:0] status, [12:2] allocated_number,
                                           // [23:13] free_count
    // Register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic                 mode_reg, mode_next;
    logic [WADDR_W-1:0]   word_addr_reg, word_addr_next;
    logic [WADDR_W-1:0]   data_addr_reg;
    logic                 pend_reg, pend_next;
    logic [BSEL_W-1:0]    free_pos_reg, free_pos_next;
    status_t              status_reg, status_next;
    logic [FIELD_W-1:0]   alloc_reg, alloc_next;
    logic [FIELD_W-1:0]   free_cnt_reg, free_cnt_next;
    logic [FIELD_W-1:0]   item_count_reg;
    logic [FIELD_W-1:0]   initial_free_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    logic                 in_xfer;
    logic                 cfg_wr;
    logic [FIELD_W-1:0]   limit;
    logic [FIELD_W-1:0]   num;
    logic [BIT_W-1:0]     num_idx;
    logic [CMP_W-1:0]     base;
    logic [CMP_W-1:0]     lim_w;
    logic [CMP_W-1:0]     rem;
    logic                 last_word;
    logic                 map_wr;
    logic [WORD_W-1:0]    map_rdata;
    word_req_t            wu_req;
    word_res_t            wu_res;

    // Handshakes
    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg   <= ITEMS_RESET;
            initial_free_reg <= INIT_FREE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ITEM_COUNT) begin
                item_count_reg <= pwdata[FIELD_W-1:0];
            end else begin
                initial_free_reg <= pwdata[FIELD_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_INITIAL_FREE) ? 32'(initial_free_reg)
                                                   : 32'(item_count_reg);

    // Active item limit and index arithmetic
    assign limit   = (item_count_reg > COUNT_LIMIT) ? COUNT_LIMIT : item_count_reg;
    assign num     = s_tdata[FIELD_W-1:0];
    assign num_idx = BIT_W'(num - FIELD_W'(1));
    assign base    = CMP_W'({data_addr_reg, {BSEL_W{1'b0}}});
    assign lim_w   = CMP_W'(limit);
    assign rem     = lim_w - base;
    assign last_word = (base + CMP_W'(WORD_W)) >= lim_w;

    // Shared word unit
    always_comb begin
        wu_req.op   = mode_reg;
        wu_req.word = map_rdata;
        wu_req.pos  = free_pos_reg;
        if (lim_w <= base) begin
            wu_req.avail = '0;
        end else if (rem >= CMP_W'(WORD_W)) begin
            wu_req.avail = AVAIL_W'(WORD_W);
        end else begin
            wu_req.avail = rem[AVAIL_W-1:0];
        end
    end

    bffa_word_unit u_word_unit (
        .req (wu_req),
        .res (wu_res)
    );

    assign map_wr = (state_reg == S_RUN) && pend_reg &&
                    ((mode_reg == MODE_FREE) || wu_res.found);

    bffa_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (word_addr_reg),
        .wr_en   (map_wr),
        .wr_addr (data_addr_reg),
        .wr_data (wu_res.wdata),
        .rd_data (map_rdata)
    );

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        word_addr_next = word_addr_reg;
        pend_next      = pend_reg;
        free_pos_next  = free_pos_reg;
        status_next    = status_reg;
        alloc_next     = alloc_reg;
        free_cnt_next  = free_cnt_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        // Result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    mode_next  = s_tuser[0];
                    pend_next  = 1'b0;
                    alloc_next = '0;
                    if (s_tuser[0] == MODE_ALLOC) begin
                        word_addr_next = '0;
                        state_next     = S_RUN;
                    end else if (num == '0 || num > limit) begin
                        status_next = ST_RANGE;
                        state_next  = S_DONE;
                    end else begin
                        word_addr_next = num_idx[BIT_W-1:BSEL_W];
                        free_pos_next  = num_idx[BSEL_W-1:0];
                        state_next     = S_RUN;
                    end
                end
            end
            S_RUN: begin
                // Read of the next word overlaps evaluation of the current one
                word_addr_next = word_addr_reg + WADDR_W'(1);
                pend_next      = 1'b1;
                if (pend_reg) begin
                    if (mode_reg == MODE_FREE) begin
                        status_next = ST_OK;
                        if (free_cnt_reg < COUNT_LIMIT) begin
                            free_cnt_next = free_cnt_reg + FIELD_W'(1);
                        end
                        state_next = S_DONE;
                    end else if (wu_res.found) begin
                        status_next = ST_OK;
                        alloc_next  = FIELD_W'(base + CMP_W'(wu_res.pos) + CMP_W'(1));
                        if (free_cnt_reg != '0) begin
                            free_cnt_next = free_cnt_reg - FIELD_W'(1);
                        end
                        state_next = S_DONE;
                    end else if (last_word) begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {free_cnt_reg, alloc_reg, status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Register write reloads the free count
        if (cfg_wr && paddr[2] == REG_INITIAL_FREE) begin
            free_cnt_next = (pwdata[FIELD_W-1:0] > COUNT_LIMIT) ? COUNT_LIMIT
                                                                : pwdata[FIELD_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            free_cnt_reg <= FREE_RESET;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            free_cnt_reg <= free_cnt_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        word_addr_reg <= word_addr_next;
        data_addr_reg <= word_addr_reg;
        free_pos_reg  <= free_pos_next;
        status_reg    <= status_next;
        alloc_reg     <= alloc_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/bffa_checker.sv
// Port-level checks of the allocator, bound to the top level.
module bffa_checker
    import bffa_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             pready
);

    // A stalled result transaction holds its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Status is one of the defined codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_FULL ||
                      m_tdata[1:0] == ST_RANGE))
        else $error("undefined status code");

    // Only a successful request carries an item number
    a_number: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[12:2] == '0)
        else $error("item number on failed request");

    // Free count never exceeds its bound
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:13] <= COUNT_LIMIT)
        else $error("free count above bound");

    // Register port never waits
    a_ready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

### verif/tb.sv
// Self-checking testbench for the bitmap first-free allocator: directed and random requests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bffa_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_TARGET = 1530;

    typedef struct {
        status_t            status;
        logic [FIELD_W-1:0] number;
        logic [FIELD_W-1:0] count;
    } alloc_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;   // [10:0] item_number, [15:11] zero
    logic [0:0]          s_tuser;   // [0] mode
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;   // [1:0] status, [12:2] allocated_number, [23:13] free_count
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Allocator mirror: used bits, free counter and the item_count register
    logic [MAX_ITEMS-1:0] used_map;
    logic [FIELD_W-1:0]   item_count_q;
    logic [FIELD_W-1:0]   free_ctr;

    alloc_result_t pending[$];
    int            sent_count;
    int            fail_count;
    int            cycle_count;
    bit            gaps_on;
    bit            stalls_on;

    bitmap_first_free_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Items in use: item_count clipped to the map size
    function automatic int active_limit();
        return (item_count_q > MAX_ITEMS) ? MAX_ITEMS : int'(item_count_q);
    endfunction

    function automatic bit map_full();
        int lim;
        lim = active_limit();
        for (int i = 0; i < lim; i++)
            if (!used_map[i]) return 1'b0;
        return 1'b1;
    endfunction

    // Apply one request to the mirror and return the result it must produce
    function automatic alloc_result_t predict_request(logic mode, logic [FIELD_W-1:0] num);
        alloc_result_t r;
        int lim;
        int slot;
        lim = active_limit();
        slot = -1;
        r.status = ST_OK;
        r.number = '0;
        if (mode == MODE_ALLOC) begin
            for (int i = 0; i < lim; i++) begin
                if (!used_map[i]) begin
                    slot = i;
                    break;
                end
            end
            if (slot >= 0) begin
                used_map[slot] = 1'b1;
                if (free_ctr != 0) free_ctr = free_ctr - 1'b1;
                r.number = FIELD_W'(slot + 1);
            end else begin
                r.status = ST_FULL;
            end
        end else if (num == 0 || num > lim) begin
            r.status = ST_RANGE;
        end else begin
            // freeing a clear bit still bumps the counter
            used_map[10'(num - 1'b1)] = 1'b0;
            if (free_ctr < COUNT_LIMIT) free_ctr = free_ctr + 1'b1;
        end
        r.count = free_ctr;
        return r;
    endfunction

    // One request transaction; returns at the falling edge after acceptance
    task automatic send_request(input logic mode, input logic [FIELD_W-1:0] num);
        if (gaps_on && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        pending.push_back(predict_request(mode, num));
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, num};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent_count++;
    endtask

    // Random request: mostly in-range numbers on free, some zero or wild
    task automatic send_random(input int alloc_pct);
        int lim;
        int pick;
        lim = active_limit();
        pick = $urandom_range(99);
        if ($urandom_range(99) < alloc_pct)
            send_request(MODE_ALLOC, FIELD_W'($urandom_range(0, 2047)));
        else if (lim > 0 && pick < 75)
            send_request(MODE_FREE, FIELD_W'($urandom_range(1, lim)));
        else if (pick < 85)
            send_request(MODE_FREE, '0);
        else
            send_request(MODE_FREE, FIELD_W'($urandom_range(0, 2047)));
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // APB write: setup then access phase, only with the block idle
    task automatic write_register(input logic idx, input logic [FIELD_W-1:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ITEM_COUNT)
            item_count_q = value;
        else
            free_ctr = (value > COUNT_LIMIT) ? COUNT_LIMIT : value;
    endtask

    // Reset values: first allocations, double free, saturation, range edges
    task automatic test_reset_state();
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, 11'h7ff);
        send_request(MODE_FREE, 11'd1);
        send_request(MODE_FREE, 11'd1);
        send_request(MODE_FREE, 11'd2);
        send_request(MODE_FREE, 11'd0);
        send_request(MODE_FREE, 11'd1025);
        send_request(MODE_FREE, 11'd2047);
        send_request(MODE_FREE, 11'd1024);
    endtask

    // Tiny map: run to full, free past the end, allocate with the counter at zero
    task automatic test_small_map();
        write_register(REG_ITEM_COUNT, 11'd3);
        write_register(REG_INITIAL_FREE, 11'd2);
        repeat (4) send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 11'd3);
        send_request(MODE_FREE, 11'd4);
        send_request(MODE_FREE, 11'd2);
        write_register(REG_INITIAL_FREE, 11'd0);
        send_request(MODE_ALLOC, '0);
    endtask

    // No items in use: allocate is full, every free out of range
    task automatic test_zero_items();
        write_register(REG_ITEM_COUNT, 11'd0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 11'd1);
        send_request(MODE_FREE, 11'd0);
    endtask

    // Register values above the map size clip to it
    task automatic test_oversized_settings();
        write_register(REG_ITEM_COUNT, 11'd2047);
        write_register(REG_INITIAL_FREE, 11'd2047);
        send_request(MODE_FREE, 11'd1024);
        send_request(MODE_FREE, 11'd1025);
        send_request(MODE_ALLOC, '0);
    endtask

    // Fill the whole map with mostly allocates, then hit full twice
    task automatic test_fill_whole_map();
        int n;
        n = 0;
        write_register(REG_ITEM_COUNT, 11'd1024);
        write_register(REG_INITIAL_FREE, 11'd1024);
        while (!map_full()) begin
            // quiet stretch with no gaps and no stalls
            gaps_on   = !(n >= 200 && n < 500);
            stalls_on = gaps_on;
            send_random(90);
            n++;
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
    endtask

    // Phases of random settings, each followed by a random request batch
    task automatic test_random_phases();
        int pick;
        int alloc_pct;
        logic [FIELD_W-1:0] count_val;
        logic [FIELD_W-1:0] free_val;
        while (sent_count < RANDOM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 60)      count_val = FIELD_W'($urandom_range(1, 40));
            else if (pick < 75) count_val = FIELD_W'($urandom_range(41, 1024));
            else if (pick < 83) count_val = 11'd1024;
            else if (pick < 90) count_val = 11'd0;
            else                count_val = FIELD_W'($urandom_range(1025, 2047));
            write_register(REG_ITEM_COUNT, count_val);
            if ($urandom_range(1) == 1) begin
                pick = $urandom_range(99);
                if (pick < 60)      free_val = FIELD_W'($urandom_range(0, 40));
                else if (pick < 80) free_val = FIELD_W'($urandom_range(0, 1024));
                else if (pick < 90) free_val = 11'd0;
                else                free_val = FIELD_W'($urandom_range(1025, 2047));
                write_register(REG_INITIAL_FREE, free_val);
            end
            gaps_on   = ($urandom_range(3) != 0);
            stalls_on = gaps_on;
            alloc_pct = $urandom_range(30, 85);
            repeat ($urandom_range(20, 70)) send_random(alloc_pct);
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Result sink backpressure
    always @(negedge aclk) begin
        m_tready <= (stalls_on && $urandom_range(99) < 13) ? 1'b0 : 1'b1;
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : check_result
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                $error("unexpected result transaction: tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = pending.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[12:2] !== want.number) begin
                    $error("allocated_number: expected %0d, got %0d",
                           want.number, m_tdata[12:2]);
                    fail_count++;
                end
                if (m_tdata[23:13] !== want.count) begin
                    $error("free_count: expected %0d, got %0d", want.count, m_tdata[23:13]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b1;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        aresetn      = 1'b0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        sent_count   = 0;
        fail_count   = 0;
        used_map     = '0;
        item_count_q = ITEMS_RESET;
        free_ctr     = FREE_RESET;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_small_map();
        test_zero_items();
        test_oversized_settings();
        test_fill_whole_map();
        test_random_phases();

        drain();
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
